@@ design/level_key_accumulate_table_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the level key accumulate table
// Shared concurrent property forms, clocked and disabled under reset.
// ----------------------------------------------------------------------------
`ifndef LEVEL_KEY_ACCUMULATE_TABLE_TOP_MACROS_SVH
`define LEVEL_KEY_ACCUMULATE_TABLE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LKAT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkat: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LKAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkat: next-cycle check failed");

`endif

@@ design/lkat_pkg.sv @@
// ----------------------------------------------------------------------------
// lkat_pkg
// Types and constants shared by the level key accumulate table modules.
// ----------------------------------------------------------------------------
package lkat_pkg;

    localparam int LEVEL_W    = 6;
    localparam int LEVELS     = 6;
    localparam int COEF_W     = 32;
    localparam int DIMS_W     = 3;
    localparam int IDX_PORT_W = 6;
    localparam int CNT_PORT_W = 7;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd2;

    typedef enum logic [1:0] {
        FUNC_ACCUM   = 2'd0,
        FUNC_COMPACT = 2'd1,
        FUNC_SET     = 2'd2,
        FUNC_READ    = 2'd3
    } lkat_func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_SAT   = 2'd3
    } lkat_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_PICK,
        S_LOAD,
        S_FINISH,
        S_SQUEEZE
    } lkat_state_t;

    typedef struct packed {
        lkat_func_t                func;
        logic [LEVEL_W-1:0]        level_0;
        logic [LEVEL_W-1:0]        level_1;
        logic [LEVEL_W-1:0]        level_2;
        logic [LEVEL_W-1:0]        level_3;
        logic [LEVEL_W-1:0]        level_4;
        logic [LEVEL_W-1:0]        level_5;
        logic signed [COEF_W-1:0]  coefficient;
        logic [IDX_PORT_W-1:0]     entry_index;
    } lkat_req_t;

    typedef struct packed {
        logic [IDX_PORT_W-1:0]     result_index;
        logic signed [COEF_W-1:0]  result_coefficient;
        logic [LEVEL_W-1:0]        out_level_0;
        logic [LEVEL_W-1:0]        out_level_1;
        logic [LEVEL_W-1:0]        out_level_2;
        logic [LEVEL_W-1:0]        out_level_3;
        logic [LEVEL_W-1:0]        out_level_4;
        logic [LEVEL_W-1:0]        out_level_5;
        logic [CNT_PORT_W-1:0]     entry_count;
        lkat_status_t              status;
    } lkat_rsp_t;

    // Per-cell write controls from the sequencer
    typedef struct packed {
        logic load_key;
        logic load_coef;
        logic shift;
    } lkat_cell_ctrl_t;

endpackage

@@ design/level_key_accumulate_table_top.sv @@
// ----------------------------------------------------------------------------
// level_key_accumulate_table_top
// Ordered table of level-vector keys with saturating Q16.16 coefficients.
// ----------------------------------------------------------------------------
// The table is a row of ENTRIES identical cells, entry 0 on the left. Every
// cell holds one key (MAX_DIMS six-bit levels) and one coefficient, compares
// its key with the held request key on its own, and can take the contents of
// its right-hand neighbor. The table starts empty after reset; cell contents
// are not cleared and only entries below the count are used.
// Operations (func): accumulate adds to the first entry whose key matches on
// the active dimensions or appends a new entry (status full when no room),
// compact drops zero-coefficient entries and keeps the order, set writes one
// coefficient by index, read returns one entry (status range when the index
// is not below the count). Sums clamp to the 32-bit range with status sat.
// Sequencing: one item is worked on at a time and req_ready is high only
// while the sequencer is idle. Accumulate, set and read write the result
// register after these steps: compare in every cell, lowest-hit select (an
// index check for set and read), entry read, then add and clamp (accumulate)
// and write back. Compact walks a pointer across the valid entries, one
// cell position per cycle while the entry under it is nonzero, and collapses
// the row one step on each zero entry, keeping the pointer; it writes its
// result register once the pointer reaches the count. The result sits in
// an output register: a result waiting on rsp_ready does not hold up the
// next accept, only the next write into that register, which stretches
// the last step by the stall. dims_in_use is written through cfg_write /
// cfg_data; the user must write it only while the table is idle, which the
// block does not enforce. 0 acts as 1; values above MAX_DIMS act as MAX_DIMS.
// ----------------------------------------------------------------------------
`include "level_key_accumulate_table_top_macros.svh"

module level_key_accumulate_table_top #(
    parameter int ENTRIES  = 64,
    parameter int MAX_DIMS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  lkat_pkg::lkat_req_t           req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output lkat_pkg::lkat_rsp_t           rsp,
    input  logic                          cfg_write,
    input  logic [lkat_pkg::DIMS_W-1:0]   cfg_data
);
    import lkat_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > IDX_PORT_W) ? CNT_W : IDX_PORT_W;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

    typedef logic [MAX_DIMS-1:0][LEVEL_W-1:0] key_t;

    // Sequencer and table state
    lkat_state_t            state_reg, state_next;
    logic [DIMS_W-1:0]      dims_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       ptr_reg, ptr_next;

    // Held request
    lkat_func_t             func_reg;
    key_t                   key_reg;
    logic [COEF_W-1:0]      coef_reg;
    logic [IDX_PORT_W-1:0]  idx_reg;

    // Select and read-out stages
    logic [ENTRIES-1:0]     hit_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       pick_reg;
    key_t                   rd_key_reg;
    logic [COEF_W-1:0]      rd_coef_reg;

    // Result register
    lkat_rsp_t              rsp_reg, rsp_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    // Cell row wiring
    lkat_cell_ctrl_t        cell_ctrl [ENTRIES];
    key_t                   cell_key  [ENTRIES];
    logic [COEF_W-1:0]      cell_coef [ENTRIES];
    logic [ENTRIES-1:0]     cell_hit;
    logic [ENTRIES-1:0]     cell_zero;
    logic [ENTRIES-1:0]     hit_live;

    logic                   pick_found;
    logic [IDX_W-1:0]       pick_index;

    logic [DIMS_W-1:0]      eff_dims;
    logic [MAX_DIMS-1:0]    dims_mask;
    key_t                   req_key;
    logic [LEVEL_W-1:0]     req_lvl [LEVELS];

    logic                   accept;
    logic                   out_free;
    logic                   emit;
    logic                   idx_in_range;
    logic [COEF_W:0]        sum;
    logic [COEF_W-1:0]      sum_sat;
    logic                   sum_ovf;

    logic                   wr_key_en;
    logic                   wr_coef_en;
    logic [IDX_W-1:0]       wr_idx;
    logic [COEF_W-1:0]      wr_coef;
    logic                   shift_go;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Clamp the dimension register into 1 .. MAX_DIMS
    always_comb
    begin
        priority if (dims_reg == '0)
        begin
            eff_dims = DIMS_W'(1);
        end
        else if (dims_reg > DIMS_W'(MAX_DIMS))
        begin
            eff_dims = DIMS_W'(MAX_DIMS);
        end
        else
        begin
            eff_dims = dims_reg;
        end
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            dims_mask[d] = (DIMS_W'(d) < eff_dims);
        end
    end

    // Zero the unused key components on the way in
    always_comb
    begin
        req_lvl[0] = req.level_0;
        req_lvl[1] = req.level_1;
        req_lvl[2] = req.level_2;
        req_lvl[3] = req.level_3;
        req_lvl[4] = req.level_4;
        req_lvl[5] = req.level_5;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            req_key[d] = dims_mask[d] ? req_lvl[d] : '0;
        end
    end

    // Cell row: each cell shifts from its right neighbor, the last from itself
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] POS = CNT_W'(i);
        localparam int               NBR = (i == ENTRIES - 1) ? i : i + 1;

        always_comb
        begin
            cell_ctrl[i].load_key  = wr_key_en  && (wr_idx == IDX_W'(i));
            cell_ctrl[i].load_coef = wr_coef_en && (wr_idx == IDX_W'(i));
            cell_ctrl[i].shift     = shift_go   && (POS >= ptr_reg);
        end

        assign hit_live[i] = cell_hit[i] && (POS < count_reg);

        lkat_cell #(
            .MAX_DIMS (MAX_DIMS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .wr_key    (key_reg),
            .wr_coef   (wr_coef),
            .nbr_key   (cell_key[NBR]),
            .nbr_coef  (cell_coef[NBR]),
            .match_key (key_reg),
            .dims_mask (dims_mask),
            .hit       (cell_hit[i]),
            .key       (cell_key[i]),
            .coef      (cell_coef[i]),
            .zero      (cell_zero[i])
        );
    end

    lkat_pick #(
        .ENTRIES (ENTRIES)
    ) u_pick (
        .hit   (hit_reg),
        .found (pick_found),
        .index (pick_index)
    );

    assign idx_in_range = (CMP_W'(idx_reg) < CMP_W'(count_reg));

    // Saturating add on the entry read out in the load stage
    always_comb
    begin
        sum     = {rd_coef_reg[COEF_W-1], rd_coef_reg} + {coef_reg[COEF_W-1], coef_reg};
        sum_ovf = (sum[COEF_W] != sum[COEF_W-1]);
        if (sum_ovf)
        begin
            sum_sat = sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum[COEF_W-1:0];
        end
    end

    function automatic lkat_rsp_t pack_entry(
        input logic [IDX_W-1:0]  idx,
        input logic [COEF_W-1:0] coef,
        input key_t              k,
        input logic [CNT_W-1:0]  cnt,
        input lkat_status_t      stat
    );
        lkat_rsp_t          r;
        logic [LEVEL_W-1:0] lv [LEVELS];
        for (int d = 0; d < LEVELS; d++)
        begin
            lv[d] = '0;
        end
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            lv[d] = k[d];
        end
        r.result_index       = IDX_PORT_W'(idx);
        r.result_coefficient = coef;
        r.out_level_0        = lv[0];
        r.out_level_1        = lv[1];
        r.out_level_2        = lv[2];
        r.out_level_3        = lv[3];
        r.out_level_4        = lv[4];
        r.out_level_5        = lv[5];
        r.entry_count        = CNT_PORT_W'(cnt);
        r.status             = stat;
        return r;
    endfunction

    function automatic lkat_rsp_t pack_empty(
        input logic [CNT_W-1:0] cnt,
        input lkat_status_t     stat
    );
        lkat_rsp_t r;
        r             = '0;
        r.entry_count = CNT_PORT_W'(cnt);
        r.status      = stat;
        return r;
    endfunction

    // Sequencer: next state, table writes and result
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        emit       = 1'b0;
        rsp_next   = rsp_reg;
        wr_key_en  = 1'b0;
        wr_coef_en = 1'b0;
        wr_idx     = pick_reg;
        wr_coef    = coef_reg;
        shift_go   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ptr_next   = '0;
                    state_next = (req.func == FUNC_COMPACT) ? S_SQUEEZE : S_MATCH;
                end
            end

            S_MATCH:
            begin
                state_next = S_PICK;
            end

            S_PICK:
            begin
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // Hold here until the result register is free
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    unique case (func_reg)
                        FUNC_ACCUM:
                        begin
                            priority if (found_reg)
                            begin
                                wr_coef_en = 1'b1;
                                wr_coef    = sum_sat;
                                rsp_next   = pack_entry(pick_reg, sum_sat, rd_key_reg,
                                    count_reg, sum_ovf ? STAT_SAT : STAT_OK);
                            end
                            else if (count_reg == CNT_FULL)
                            begin
                                rsp_next = pack_empty(count_reg, STAT_FULL);
                            end
                            else
                            begin
                                wr_key_en  = 1'b1;
                                wr_coef_en = 1'b1;
                                wr_idx     = IDX_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                                rsp_next   = pack_entry(IDX_W'(count_reg), coef_reg, key_reg,
                                    count_next, STAT_OK);
                            end
                        end
                        FUNC_SET:
                        begin
                            if (found_reg)
                            begin
                                wr_coef_en = 1'b1;
                                rsp_next   = pack_entry(pick_reg, coef_reg, rd_key_reg,
                                    count_reg, STAT_OK);
                            end
                            else
                            begin
                                rsp_next = pack_empty(count_reg, STAT_RANGE);
                            end
                        end
                        FUNC_READ:
                        begin
                            if (found_reg)
                            begin
                                rsp_next = pack_entry(pick_reg, rd_coef_reg, rd_key_reg,
                                    count_reg, STAT_OK);
                            end
                            else
                            begin
                                rsp_next = pack_empty(count_reg, STAT_RANGE);
                            end
                        end
                        default:
                        begin
                            rsp_next = pack_empty(count_reg, STAT_OK);
                        end
                    endcase
                end
            end

            S_SQUEEZE:
            begin
                priority if (ptr_reg >= count_reg)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        rsp_next   = pack_empty(count_reg, STAT_OK);
                        state_next = S_IDLE;
                    end
                end
                else if (cell_zero[ptr_reg[IDX_W-1:0]])
                begin
                    // Collapse the row onto the zero entry, keep the pointer
                    shift_go   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        priority if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dims_reg      <= DIMS_RESET;
            count_reg     <= '0;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
            begin
                dims_reg <= cfg_data;
            end
        end
    end

    // Payload: request hold, select stages and result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            key_reg  <= req_key;
            coef_reg <= req.coefficient;
            idx_reg  <= req.entry_index;
        end
        if (state_reg == S_MATCH)
        begin
            hit_reg <= hit_live;
        end
        if (state_reg == S_PICK)
        begin
            if (func_reg == FUNC_ACCUM)
            begin
                found_reg <= pick_found;
                pick_reg  <= pick_index;
            end
            else
            begin
                found_reg <= idx_in_range;
                pick_reg  <= IDX_W'(idx_reg);
            end
        end
        if (state_reg == S_LOAD)
        begin
            rd_key_reg  <= cell_key[pick_reg];
            rd_coef_reg <= cell_coef[pick_reg];
        end
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Checks
    `LKAT_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL)
    `LKAT_ASSERT_NEXT(a_squeeze_no_grow, clk, rst_n, state_reg == S_SQUEEZE,
        count_reg <= $past(count_reg))
    `LKAT_ASSERT_SAME(a_emit_slot_free, clk, rst_n, emit, !rsp_valid_reg || rsp_ready)
    `LKAT_ASSERT_SAME(a_pick_is_hit, clk, rst_n,
        state_reg == S_LOAD && func_reg == FUNC_ACCUM && found_reg, hit_reg[pick_reg])

endmodule

@@ design/lkat_cell.sv @@
// ----------------------------------------------------------------------------
// lkat_cell
// One table entry: stored key and coefficient, local key compare, and a
// left-shift path that takes the right-hand neighbor's contents.
// ----------------------------------------------------------------------------
module lkat_cell #(
    parameter int MAX_DIMS = 6
) (
    input  logic                                          clk,
    input  lkat_pkg::lkat_cell_ctrl_t                     ctrl,
    input  logic [MAX_DIMS-1:0][lkat_pkg::LEVEL_W-1:0]    wr_key,
    input  logic [lkat_pkg::COEF_W-1:0]                   wr_coef,
    input  logic [MAX_DIMS-1:0][lkat_pkg::LEVEL_W-1:0]    nbr_key,
    input  logic [lkat_pkg::COEF_W-1:0]                   nbr_coef,
    input  logic [MAX_DIMS-1:0][lkat_pkg::LEVEL_W-1:0]    match_key,
    input  logic [MAX_DIMS-1:0]                           dims_mask,
    output logic                                          hit,
    output logic [MAX_DIMS-1:0][lkat_pkg::LEVEL_W-1:0]    key,
    output logic [lkat_pkg::COEF_W-1:0]                   coef,
    output logic                                          zero
);
    import lkat_pkg::*;

    logic [MAX_DIMS-1:0][LEVEL_W-1:0] key_reg;
    logic [COEF_W-1:0]                coef_reg;
    logic [MAX_DIMS-1:0]              dim_eq;

    // Shift and load never coincide; shift wins by order only for safety
    always_ff @(posedge clk)
    begin
        priority if (ctrl.shift)
        begin
            key_reg  <= nbr_key;
            coef_reg <= nbr_coef;
        end
        else
        begin
            if (ctrl.load_key)
            begin
                key_reg <= wr_key;
            end
            if (ctrl.load_coef)
            begin
                coef_reg <= wr_coef;
            end
        end
    end

    // Ignore components outside the active dimension count
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            dim_eq[d] = !dims_mask[d] || (key_reg[d] == match_key[d]);
        end
    end

    assign hit  = &dim_eq;
    assign key  = key_reg;
    assign coef = coef_reg;
    assign zero = (coef_reg == '0);

endmodule

@@ design/lkat_pick.sv @@
// ----------------------------------------------------------------------------
// lkat_pick
// Lowest-index select over the registered hit vector of the cell row.
// ----------------------------------------------------------------------------
module lkat_pick #(
    parameter int ENTRIES = 64
) (
    input  logic [ENTRIES-1:0]         hit,
    output logic                       found,
    output logic [$clog2(ENTRIES)-1:0] index
);
    localparam int IDX_W = $clog2(ENTRIES);

    // Walk from the top so the lowest set bit lands last
    always_comb
    begin
        index = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                index = IDX_W'(i);
            end
        end
    end

    assign found = |hit;

endmodule
